FILE: hdl/dwesm_pkg.sv
package dwesm_pkg;

    localparam int VAL_W = 64;
    localparam int ACT_W = 8;
    localparam int ST_W  = 3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW   = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_REGS     = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_FRAME    = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_OBJECT   = 3'd5;
    localparam logic [ST_W-1:0] ST_UNSUPPORTED = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_HAS_REGS    = 2'd0;
    localparam logic [1:0] CFG_FRAME_BASE  = 2'd1;
    localparam logic [1:0] CFG_HAS_OBJECT  = 2'd2;
    localparam logic [1:0] CFG_OBJECT_BASE = 2'd3;

    // operation code bytes
    localparam logic [ACT_W-1:0] OP_ADDR        = 8'h03;
    localparam logic [ACT_W-1:0] OP_DEREF       = 8'h06;
    localparam logic [ACT_W-1:0] OP_CONST1U     = 8'h08;
    localparam logic [ACT_W-1:0] OP_CONST2S     = 8'h0b;
    localparam logic [ACT_W-1:0] OP_CONST4U     = 8'h0c;
    localparam logic [ACT_W-1:0] OP_CONST8U     = 8'h0e;
    localparam logic [ACT_W-1:0] OP_CONSTU      = 8'h10;
    localparam logic [ACT_W-1:0] OP_CONSTS      = 8'h11;
    localparam logic [ACT_W-1:0] OP_DUP         = 8'h12;
    localparam logic [ACT_W-1:0] OP_DROP        = 8'h13;
    localparam logic [ACT_W-1:0] OP_OVER        = 8'h14;
    localparam logic [ACT_W-1:0] OP_SWAP        = 8'h16;
    localparam logic [ACT_W-1:0] OP_AND         = 8'h1a;
    localparam logic [ACT_W-1:0] OP_MINUS       = 8'h1c;
    localparam logic [ACT_W-1:0] OP_MUL         = 8'h1e;
    localparam logic [ACT_W-1:0] OP_NEG         = 8'h1f;
    localparam logic [ACT_W-1:0] OP_NOT         = 8'h20;
    localparam logic [ACT_W-1:0] OP_OR          = 8'h21;
    localparam logic [ACT_W-1:0] OP_PLUS        = 8'h22;
    localparam logic [ACT_W-1:0] OP_PLUS_UCONST = 8'h23;
    localparam logic [ACT_W-1:0] OP_XOR         = 8'h27;
    localparam logic [ACT_W-1:0] OP_LIT0        = 8'h30;
    localparam logic [ACT_W-1:0] OP_LIT31       = 8'h4f;
    localparam logic [ACT_W-1:0] OP_BREG0       = 8'h70;
    localparam logic [ACT_W-1:0] OP_BREG31      = 8'h8f;
    localparam logic [ACT_W-1:0] OP_FBREG       = 8'h91;
    localparam logic [ACT_W-1:0] OP_NOP         = 8'h96;

    // stack update commands
    localparam logic [2:0] SC_HOLD = 3'd0;
    localparam logic [2:0] SC_PUSH = 3'd1;
    localparam logic [2:0] SC_POP  = 3'd2;  // drop top, new top from value
    localparam logic [2:0] SC_SET  = 3'd3;  // replace top
    localparam logic [2:0] SC_SWAP = 3'd4;

    typedef struct packed {
        logic [2:0]       kind;
        logic [VAL_W-1:0] value;
        logic             clear;
    } stack_cmd_t;

endpackage

FILE: hdl/dwesm_mul.sv
module dwesm_mul (
    input  logic                   clk,
    input  logic                   start,
    input  logic [dwesm_pkg::VAL_W-1:0] a,
    input  logic [dwesm_pkg::VAL_W-1:0] b,
    output logic [dwesm_pkg::VAL_W-1:0] product
);
    import dwesm_pkg::*;

    logic [63:0] ll_next;
    logic [31:0] lh_next;
    logic [31:0] hl_next;
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [31:0] mid_sum;

    // low 64 bits only: the high-by-high partial product never reaches them
    assign ll_next = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    assign lh_next = a[31:0] * b[63:32];
    assign hl_next = a[63:32] * b[31:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
        end
    end

    assign mid_sum = lh_reg + hl_reg;
    assign product = ll_reg + {mid_sum, 32'b0};

endmodule

FILE: hdl/dwesm_stack.sv
module dwesm_stack #(
    parameter int STACK_DEPTH = 16,
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1),
    localparam int ADDR_W = $clog2(STACK_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  dwesm_pkg::stack_cmd_t       cmd,
    output logic [dwesm_pkg::VAL_W-1:0] top,
    output logic [dwesm_pkg::VAL_W-1:0] nxt,
    output logic [CNT_W-1:0]            count
);
    import dwesm_pkg::*;

    localparam int MEM_N = 1 << ADDR_W;

    // top two entries live in flops, the rest below them in the memory
    logic [VAL_W-1:0] top_reg;
    logic [VAL_W-1:0] top_next;
    logic [VAL_W-1:0] nxt_reg;
    logic [VAL_W-1:0] nxt_next;
    logic [VAL_W-1:0] below_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [VAL_W-1:0] mem [MEM_N];
    logic             mem_we;
    logic [CNT_W-1:0] wsub;
    logic [CNT_W-1:0] rsub;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    always_comb
    begin
        top_next   = top_reg;
        nxt_next   = nxt_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        if (apply)
        begin
            unique case (cmd.kind)
                SC_PUSH:
                begin
                    top_next   = cmd.value;
                    nxt_next   = top_reg;
                    count_next = count_reg + CNT_W'(1);
                    mem_we     = (count_reg >= CNT_W'(2));
                end
                SC_POP:
                begin
                    top_next   = cmd.value;
                    nxt_next   = below_reg;
                    count_next = count_reg - CNT_W'(1);
                end
                SC_SET:
                begin
                    top_next = cmd.value;
                end
                SC_SWAP:
                begin
                    top_next = nxt_reg;
                    nxt_next = top_reg;
                end
                default:
                begin
                end
            endcase
            if (cmd.clear)
            begin
                count_next = '0;
            end
        end
    end

    // spill slot is count-2; entry under the second one is count-3
    assign wsub  = count_reg - CNT_W'(2);
    assign rsub  = count_next - CNT_W'(3);
    assign waddr = wsub[ADDR_W-1:0];
    assign raddr = rsub[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        nxt_reg <= nxt_next;
    end

    // below_reg always holds entry count-3, forwarded on a spill to that slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= nxt_reg;
        end
        if (mem_we && (waddr == raddr))
        begin
            below_reg <= nxt_reg;
        end
        else
        begin
            below_reg <= mem[raddr];
        end
    end

    assign top   = top_reg;
    assign nxt   = nxt_reg;
    assign count = count_reg;

endmodule

FILE: hdl/dwesm_exec.sv
module dwesm_exec #(
    parameter int STACK_DEPTH = 16,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
    input  logic [dwesm_pkg::ACT_W-1:0] action,
    input  logic [dwesm_pkg::VAL_W-1:0] operand,
    input  logic [dwesm_pkg::VAL_W-1:0] reg_value,
    input  logic                        last,
    input  logic                        has_register_context,
    input  logic [dwesm_pkg::VAL_W-1:0] frame_base_addr,
    input  logic                        has_object_base,
    input  logic [dwesm_pkg::VAL_W-1:0] object_base,
    input  logic [dwesm_pkg::ST_W-1:0]  latched_error,
    input  logic [dwesm_pkg::VAL_W-1:0] top,
    input  logic [dwesm_pkg::VAL_W-1:0] nxt,
    input  logic [CNT_W-1:0]            count,
    input  logic [dwesm_pkg::VAL_W-1:0] mul_product,
    output dwesm_pkg::stack_cmd_t       cmd,
    output logic                        mul_need,
    output logic [dwesm_pkg::ST_W-1:0]  status,
    output logic [dwesm_pkg::VAL_W-1:0] res_top,
    output logic [CNT_W-1:0]            res_depth
);
    import dwesm_pkg::*;

    localparam logic [3:0] K_BAD   = 4'd0;
    localparam logic [3:0] K_BREG  = 4'd1;
    localparam logic [3:0] K_LIT   = 4'd2;
    localparam logic [3:0] K_CONST = 4'd3;
    localparam logic [3:0] K_FBREG = 4'd4;
    localparam logic [3:0] K_ADDR  = 4'd5;
    localparam logic [3:0] K_DUP   = 4'd6;
    localparam logic [3:0] K_DROP  = 4'd7;
    localparam logic [3:0] K_OVER  = 4'd8;
    localparam logic [3:0] K_SWAP  = 4'd9;
    localparam logic [3:0] K_BIN   = 4'd10;
    localparam logic [3:0] K_PLUSU = 4'd11;
    localparam logic [3:0] K_NOT   = 4'd12;
    localparam logic [3:0] K_NEG   = 4'd13;
    localparam logic [3:0] K_NOP   = 4'd14;

    logic [3:0]       kind;
    logic             has1;
    logic             has2;
    logic             full;
    logic             want_push;
    logic [VAL_W-1:0] push_val;
    logic [VAL_W-1:0] alu;
    logic [ST_W-1:0]  st;
    logic [2:0]       ck;
    logic [VAL_W-1:0] v;
    logic [CNT_W-1:0] cnt_after;
    logic [VAL_W-1:0] sel_top;

    always_comb
    begin
        priority if (action >= OP_BREG0 && action <= OP_BREG31)
            kind = K_BREG;
        else if (action >= OP_LIT0 && action <= OP_LIT31)
            kind = K_LIT;
        else if (action >= OP_CONST1U && action <= OP_CONSTS)
            kind = K_CONST;
        else if (action == OP_FBREG)
            kind = K_FBREG;
        else if (action == OP_ADDR)
            kind = K_ADDR;
        else if (action == OP_DUP)
            kind = K_DUP;
        else if (action == OP_DROP)
            kind = K_DROP;
        else if (action == OP_OVER)
            kind = K_OVER;
        else if (action == OP_SWAP)
            kind = K_SWAP;
        else if (action == OP_AND || action == OP_MINUS || action == OP_MUL ||
                 action == OP_OR || action == OP_PLUS || action == OP_XOR)
            kind = K_BIN;
        else if (action == OP_PLUS_UCONST)
            kind = K_PLUSU;
        else if (action == OP_NOT)
            kind = K_NOT;
        else if (action == OP_NEG)
            kind = K_NEG;
        else if (action == OP_NOP)
            kind = K_NOP;
        else
            kind = K_BAD;
    end

    // second-from-top is the left operand
    always_comb
    begin
        unique case (action)
            OP_AND:   alu = nxt & top;
            OP_MINUS: alu = nxt - top;
            OP_MUL:   alu = mul_product;
            OP_OR:    alu = nxt | top;
            OP_PLUS:  alu = nxt + top;
            default:  alu = nxt ^ top;
        endcase
    end

    assign has1 = (count != '0);
    assign has2 = (count >= CNT_W'(2));
    assign full = (count >= CNT_W'(STACK_DEPTH));

    always_comb
    begin
        st        = ST_OK;
        ck        = SC_HOLD;
        v         = top;
        want_push = 1'b0;
        push_val  = operand;
        unique case (kind)
            K_BREG:
            begin
                if (!has_register_context)
                    st = ST_NO_REGS;
                else
                begin
                    want_push = 1'b1;
                    push_val  = reg_value + operand;
                end
            end
            K_LIT:
            begin
                want_push = 1'b1;
                push_val  = VAL_W'(action - OP_LIT0);
            end
            K_CONST:
            begin
                want_push = 1'b1;
            end
            K_FBREG:
            begin
                if (frame_base_addr == '0)
                    st = ST_NO_FRAME;
                else
                begin
                    want_push = 1'b1;
                    push_val  = frame_base_addr + operand;
                end
            end
            K_ADDR:
            begin
                if (!has_object_base)
                    st = ST_NO_OBJECT;
                else
                begin
                    want_push = 1'b1;
                    push_val  = object_base + operand;
                end
            end
            K_DUP:
            begin
                if (!has1)
                    st = ST_UNDERFLOW;
                else
                begin
                    want_push = 1'b1;
                    push_val  = top;
                end
            end
            K_DROP:
            begin
                if (!has1)
                    st = ST_UNDERFLOW;
                else
                begin
                    ck = SC_POP;
                    v  = nxt;
                end
            end
            K_OVER:
            begin
                if (!has2)
                    st = ST_UNDERFLOW;
                else
                begin
                    want_push = 1'b1;
                    push_val  = nxt;
                end
            end
            K_SWAP:
            begin
                if (!has2)
                    st = ST_UNDERFLOW;
                else
                    ck = SC_SWAP;
            end
            K_BIN:
            begin
                if (!has2)
                    st = ST_UNDERFLOW;
                else
                begin
                    ck = SC_POP;
                    v  = alu;
                end
            end
            K_PLUSU:
            begin
                if (!has1)
                    st = ST_UNDERFLOW;
                else
                begin
                    ck = SC_SET;
                    v  = top + operand;
                end
            end
            K_NOT:
            begin
                if (!has1)
                    st = ST_UNDERFLOW;
                else
                begin
                    ck = SC_SET;
                    v  = ~top;
                end
            end
            K_NEG:
            begin
                if (!has1)
                    st = ST_UNDERFLOW;
                else
                begin
                    ck = SC_SET;
                    v  = VAL_W'(0) - top;
                end
            end
            K_NOP:
            begin
            end
            default:
            begin
                st = ST_UNSUPPORTED;
            end
        endcase

        if (want_push)
        begin
            if (full)
                st = ST_OVERFLOW;
            else
            begin
                ck = SC_PUSH;
                v  = push_val;
            end
        end

        // a latched error freezes the stack until the expression ends
        if (latched_error != ST_OK)
        begin
            st = latched_error;
            ck = SC_HOLD;
        end
    end

    always_comb
    begin
        unique case (ck)
            SC_PUSH: cnt_after = count + CNT_W'(1);
            SC_POP:  cnt_after = count - CNT_W'(1);
            default: cnt_after = count;
        endcase
        unique case (ck)
            SC_HOLD: sel_top = top;
            SC_SWAP: sel_top = nxt;
            default: sel_top = v;
        endcase
    end

    assign mul_need  = (latched_error == ST_OK) && (kind == K_BIN) && has2 &&
                       (action == OP_MUL);
    assign status    = st;
    assign res_depth = cnt_after;
    assign res_top   = (cnt_after == '0) ? '0 : sel_top;
    assign cmd       = '{kind: ck, value: v, clear: last};

endmodule

FILE: hdl/dwarf_expression_stack_machine_unit.sv
// DWARF location expression evaluator.
// Operations come in on the s_axis stream, one beat per DW_OP with its decoded
// operand and, for bregN, the register value; tlast marks the end of an
// expression. Each input beat gives exactly one m_axis beat with the status,
// the top of stack and the depth; tlast on it echoes the input tlast.
// Context (register availability, frame base, object base) is written on the
// cfg channel, index 0..3. The user must write it only while no beat is in
// flight; the block has no check. A beat passes the input register, then the
// result register. One beat per cycle is sustained while m_axis_tready is
// high; DW_OP_mul stalls to load the split 32-bit partial-product multiplier.
// The first error is held and reported until the beat with tlast, after
// which the stack and the error clear.
// Reset (rst_n low) empties the stack, clears the error and the context.
// When m_axis_tready is low the result register holds; the input side takes
// one more beat only if its register is empty, then s_axis_tready drops.
module dwarf_expression_stack_machine_unit #(
    parameter int STACK_DEPTH = 16,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W = ((67 + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [135:0]     s_axis_tdata,  // action[7:0], operand, reg_value
    input  logic             s_axis_tlast,  // last_op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // status[2:0], top_value, depth
    output logic             m_axis_tlast,  // done_res
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import dwesm_pkg::*;

    logic             has_regs_reg;
    logic [VAL_W-1:0] frame_base_reg;
    logic             has_obj_reg;
    logic [VAL_W-1:0] obj_base_reg;

    logic             x_valid_reg;
    logic [ACT_W-1:0] x_action_reg;
    logic [VAL_W-1:0] x_operand_reg;
    logic [VAL_W-1:0] x_regval_reg;
    logic             x_last_reg;

    logic             o_valid_reg;
    logic [ST_W-1:0]  o_status_reg;
    logic [VAL_W-1:0] o_top_reg;
    logic [CNT_W-1:0] o_depth_reg;
    logic             o_last_reg;

    logic [ST_W-1:0]  err_reg;
    logic [ST_W-1:0]  err_next;
    logic             mul_busy_reg;
    logic             mul_busy_next;

    logic             in_fire;
    logic             out_free;
    logic             x_fire;
    logic             mul_start;
    logic             mul_need;
    stack_cmd_t       cmd;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] res_top;
    logic [CNT_W-1:0] res_depth;
    logic [VAL_W-1:0] top;
    logic [VAL_W-1:0] nxt;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] mul_product;

    dwesm_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
        .action               (x_action_reg),
        .operand              (x_operand_reg),
        .reg_value            (x_regval_reg),
        .last                 (x_last_reg),
        .has_register_context (has_regs_reg),
        .frame_base_addr      (frame_base_reg),
        .has_object_base      (has_obj_reg),
        .object_base          (obj_base_reg),
        .latched_error        (err_reg),
        .top                  (top),
        .nxt                  (nxt),
        .count                (count),
        .mul_product          (mul_product),
        .cmd                  (cmd),
        .mul_need             (mul_need),
        .status               (status),
        .res_top              (res_top),
        .res_depth            (res_depth)
    );

    dwesm_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (x_fire),
        .cmd   (cmd),
        .top   (top),
        .nxt   (nxt),
        .count (count)
    );

    dwesm_mul u_mul (
        .clk     (clk),
        .start   (mul_start),
        .a       (nxt),
        .b       (top),
        .product (mul_product)
    );

    // a mul first loads the partial products; the beat fires once mul_busy_reg is set
    assign out_free  = !o_valid_reg || m_axis_tready;
    assign x_fire    = x_valid_reg && out_free && (!mul_need || mul_busy_reg);
    assign mul_start = x_valid_reg && mul_need && !mul_busy_reg;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !x_valid_reg || x_fire;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        err_next = err_reg;
        if (x_fire)
            err_next = x_last_reg ? ST_OK : status;

        mul_busy_next = mul_busy_reg;
        if (mul_start)
            mul_busy_next = 1'b1;
        else if (x_fire)
            mul_busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
            err_reg        <= ST_OK;
            mul_busy_reg   <= 1'b0;
            has_regs_reg   <= 1'b0;
            frame_base_reg <= '0;
            has_obj_reg    <= 1'b0;
            obj_base_reg   <= '0;
        end
        else
        begin
            err_reg      <= err_next;
            mul_busy_reg <= mul_busy_next;

            if (in_fire)
                x_valid_reg <= 1'b1;
            else if (x_fire)
                x_valid_reg <= 1'b0;

            if (x_fire)
                o_valid_reg <= 1'b1;
            else if (m_axis_tready)
                o_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HAS_REGS:    has_regs_reg   <= cfg_data[0];
                    CFG_FRAME_BASE:  frame_base_reg <= cfg_data;
                    CFG_HAS_OBJECT:  has_obj_reg    <= cfg_data[0];
                    CFG_OBJECT_BASE: obj_base_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_action_reg  <= s_axis_tdata[7:0];
            x_operand_reg <= s_axis_tdata[71:8];
            x_regval_reg  <= s_axis_tdata[135:72];
            x_last_reg    <= s_axis_tlast;
        end
        if (x_fire)
        begin
            o_status_reg <= status;
            o_top_reg    <= res_top;
            o_depth_reg  <= res_depth;
            o_last_reg   <= x_last_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = OUT_W'({o_depth_reg, o_top_reg, o_status_reg});
    assign m_axis_tlast  = o_last_reg;

endmodule

FILE: tb/sv/dwarf_expression_stack_machine_unit_tb.sv
module dwarf_expression_stack_machine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwesm_pkg::*;

    localparam int STACK_SLOTS = 16;
    localparam int OUT_BITS    = 72;
    localparam int ITEMS_TOTAL = 1750;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [7:0]  action;
        logic [63:0] operand;
        logic [63:0] reg_value;
        logic        last;
    } dw_op_t;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] top;
        logic [4:0]  depth;
        logic        done;
    } dw_answer_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [135:0]        s_axis_tdata;   // action[7:0], operand, reg_value
    logic                s_axis_tlast;   // last_op
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;   // status[2:0], top_value, depth
    logic                m_axis_tlast;   // done_res
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [63:0]         cfg_data;

    dwarf_expression_stack_machine_unit #(.STACK_DEPTH(STACK_SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // evaluator shadow state
    logic [63:0] stk [STACK_SLOTS];
    int          sp       = 0;
    logic [2:0]  held_err = ST_OK;
    logic        ctx_regs = 1'b0;
    logic [63:0] ctx_frame = '0;
    logic        ctx_obj  = 1'b0;
    logic [63:0] ctx_base = '0;

    dw_op_t      op_q [$];
    dw_answer_t  answer_q [$];
    int unsigned ops_queued = 0;
    int unsigned ops_taken  = 0;
    int unsigned cfg_writes = 0;
    int unsigned bad        = 0;
    int unsigned cycles     = 0;
    logic        in_taken   = 1'b0;
    int          src_gap    = 0;
    int          sink_gap   = 0;
    int          src_odds   = 10;
    int          sink_odds  = 10;
    bit          quiet_tail = 1'b0;

    function automatic logic [2:0] push_value(logic [63:0] v);
        if (sp >= STACK_SLOTS)
            return ST_OVERFLOW;
        stk[sp] = v;
        sp++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] dw_exec(dw_op_t op);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        if (op.action >= OP_BREG0 && op.action <= OP_BREG31)
        begin
            if (!ctx_regs)
                return ST_NO_REGS;
            return push_value(op.reg_value + op.operand);
        end
        if (op.action >= OP_LIT0 && op.action <= OP_LIT31)
            return push_value(64'(op.action - OP_LIT0));
        if (op.action >= OP_CONST1U && op.action <= OP_CONSTS)
            return push_value(op.operand);
        case (op.action)
            OP_FBREG:
            begin
                if (ctx_frame == '0)
                    return ST_NO_FRAME;
                return push_value(ctx_frame + op.operand);
            end
            OP_ADDR:
            begin
                if (!ctx_obj)
                    return ST_NO_OBJECT;
                return push_value(ctx_base + op.operand);
            end
            OP_DUP:
            begin
                if (sp == 0)
                    return ST_UNDERFLOW;
                return push_value(stk[sp-1]);
            end
            OP_DROP:
            begin
                if (sp == 0)
                    return ST_UNDERFLOW;
                sp--;
                return ST_OK;
            end
            OP_OVER:
            begin
                if (sp < 2)
                    return ST_UNDERFLOW;
                return push_value(stk[sp-2]);
            end
            OP_SWAP:
            begin
                if (sp < 2)
                    return ST_UNDERFLOW;
                a = stk[sp-2];
                stk[sp-2] = stk[sp-1];
                stk[sp-1] = a;
                return ST_OK;
            end
            OP_AND, OP_MINUS, OP_MUL, OP_OR, OP_PLUS, OP_XOR:
            begin
                if (sp < 2)
                    return ST_UNDERFLOW;
                a = stk[sp-2];
                b = stk[sp-1];
                case (op.action)
                    OP_AND:   r = a & b;
                    OP_MINUS: r = a - b;
                    OP_MUL:   r = a * b;
                    OP_OR:    r = a | b;
                    OP_PLUS:  r = a + b;
                    default:  r = a ^ b;
                endcase
                stk[sp-2] = r;
                sp--;
                return ST_OK;
            end
            OP_PLUS_UCONST, OP_NOT, OP_NEG:
            begin
                if (sp == 0)
                    return ST_UNDERFLOW;
                case (op.action)
                    OP_PLUS_UCONST: stk[sp-1] = stk[sp-1] + op.operand;
                    OP_NOT:         stk[sp-1] = ~stk[sp-1];
                    default:        stk[sp-1] = 64'd0 - stk[sp-1];
                endcase
                return ST_OK;
            end
            OP_NOP:
                return ST_OK;
            default:
                return ST_UNSUPPORTED;
        endcase
    endfunction

    // one beat through the evaluator; the error sticks until the closing beat
    function automatic dw_answer_t dw_evaluate(dw_op_t op);
        dw_answer_t res;
        if (held_err == ST_OK)
            held_err = dw_exec(op);
        res.status = held_err;
        res.top    = (sp != 0) ? stk[sp-1] : '0;
        res.depth  = 5'(sp);
        res.done   = op.last;
        if (op.last)
        begin
            sp       = 0;
            held_err = ST_OK;
        end
        return res;
    endfunction

    // source side
    always @(negedge clk)
    begin : feed
        dw_op_t op;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet_tail && src_odds != 0 && $urandom_range(0, src_odds) == 0)
            begin
                src_gap = $urandom_range(0, 18);
                s_axis_tvalid <= 1'b0;
            end
            else if (op_q.size() != 0)
            begin
                op = op_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {op.reg_value, op.operand, op.action};
                s_axis_tlast  <= op.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet_tail && sink_odds != 0 && $urandom_range(0, sink_odds) == 0)
        begin
            sink_gap = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : observe
        dw_answer_t want;
        dw_answer_t got;
        dw_op_t     op;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HAS_REGS:    ctx_regs  = cfg_data[0];
                    CFG_FRAME_BASE:  ctx_frame = cfg_data;
                    CFG_HAS_OBJECT:  ctx_obj   = cfg_data[0];
                    CFG_OBJECT_BASE: ctx_base  = cfg_data;
                endcase
                cfg_writes++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[2:0];
                got.top    = m_axis_tdata[66:3];
                got.depth  = m_axis_tdata[71:67];
                got.done   = m_axis_tlast;
                if (answer_q.size() == 0)
                begin
                    $error("result beat with no operation outstanding");
                    bad++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        bad++;
                    end
                    if (got.top !== want.top)
                    begin
                        $error("top_value: expected %h, got %h", want.top, got.top);
                        bad++;
                    end
                    if (got.depth !== want.depth)
                    begin
                        $error("depth: expected %0d, got %0d", want.depth, got.depth);
                        bad++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done, got.done);
                        bad++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                op.action    = s_axis_tdata[7:0];
                op.operand   = s_axis_tdata[71:8];
                op.reg_value = s_axis_tdata[135:72];
                op.last      = s_axis_tlast;
                answer_q.push_back(dw_evaluate(op));
                ops_taken++;
            end
        end
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 64'd1;
            3:       return TOP_BIT;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] rand_push();
        case ($urandom_range(0, 5))
            0, 1:    return OP_LIT0 + 8'($urandom_range(0, 31));
            2:       return OP_CONST1U + 8'($urandom_range(0, 9));
            3:       return OP_BREG0 + 8'($urandom_range(0, 31));
            4:       return OP_FBREG;
            default: return OP_ADDR;
        endcase
    endfunction

    task automatic queue_op(logic [7:0] act, logic [63:0] opd, logic [63:0] rv, logic last);
        dw_op_t op;
        op.action    = act;
        op.operand   = opd;
        op.reg_value = rv;
        op.last      = last;
        op_q.push_back(op);
        ops_queued++;
    endtask

    // mostly sensible expressions; now and then a stray code or a deep push run
    task automatic add_expression(output int n);
        int         len;
        int         d;
        int         pick;
        bit         deep;
        logic [7:0] act;
        deep = ($urandom_range(0, 9) == 0);
        len  = deep ? $urandom_range(15, 22) : $urandom_range(1, 12);
        d    = 0;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                act = 8'($urandom_range(0, 255));
            else if (d == 0 || pick < (deep ? 85 : 40) || (pick >= 60 && d < 2))
            begin
                act = rand_push();
                d++;
            end
            else if (pick < 60)
            begin
                case ($urandom_range(0, 5))
                    0: act = OP_NOT;
                    1: act = OP_NEG;
                    2: act = OP_PLUS_UCONST;
                    3:
                    begin
                        act = OP_DUP;
                        d++;
                    end
                    4:
                    begin
                        act = OP_DROP;
                        d--;
                    end
                    default: act = OP_NOP;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: act = OP_AND;
                    1: act = OP_MINUS;
                    2: act = OP_MUL;
                    3: act = OP_OR;
                    4: act = OP_PLUS;
                    5: act = OP_XOR;
                    6: act = OP_SWAP;
                    default: act = OP_OVER;
                endcase
                if (act == OP_OVER)
                    d++;
                else if (act != OP_SWAP)
                    d--;
            end
            queue_op(act, rand64(), rand64(), k == len - 1);
        end
        n = len;
    endtask

    task automatic wait_drained(int settle);
        do
            @(negedge clk);
        while (ops_taken != ops_queued || answer_q.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_put(logic [1:0] idx, logic [63:0] val);
        int unsigned want;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        want = cfg_writes + 1;
        do
            @(negedge clk);
        while (cfg_writes != want);
    endtask

    task automatic write_context(logic regs, logic [63:0] frame, logic obj, logic [63:0] base);
        @(negedge clk);
        cfg_put(CFG_HAS_REGS, {63'd0, regs});
        cfg_put(CFG_FRAME_BASE, frame);
        cfg_put(CFG_HAS_OBJECT, {63'd0, obj});
        cfg_put(CFG_OBJECT_BASE, base);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int n;
        int made;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_HAS_REGS;
        cfg_data      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no context at all: each context-dependent push fails, plus bad code and empty drop
        queue_op(OP_BREG0, 64'd5, ALL_ONES, 1'b1);
        queue_op(OP_FBREG, 64'd1, '0, 1'b1);
        queue_op(OP_ADDR, ALL_ONES, '0, 1'b1);
        queue_op(OP_DEREF, '0, '0, 1'b1);
        queue_op(OP_DROP, '0, '0, 1'b1);
        wait_drained(4);

        write_context(1'b1, ALL_ONES, 1'b1, ALL_ONES);
        // fill the stack to the brim with wrapping pushes, then overflow it
        queue_op(OP_LIT0, ALL_ONES, '0, 1'b0);
        queue_op(OP_LIT31, '0, '0, 1'b0);
        queue_op(OP_CONST1U, '0, '0, 1'b0);
        queue_op(OP_CONSTS, ALL_ONES, '0, 1'b0);
        queue_op(OP_CONST8U, TOP_BIT, '0, 1'b0);
        queue_op(OP_BREG0, 64'd1, ALL_ONES, 1'b0);
        queue_op(OP_BREG31, ALL_ONES, '0, 1'b0);
        queue_op(OP_FBREG, 64'd1, '0, 1'b0);
        queue_op(OP_ADDR, ALL_ONES, '0, 1'b0);
        queue_op(OP_DUP, '0, '0, 1'b0);
        queue_op(OP_OVER, '0, '0, 1'b0);
        queue_op(OP_CONST2S, 64'hffff_ffff_ffff_8000, '0, 1'b0);
        queue_op(OP_CONST4U, 64'hffff_ffff, '0, 1'b0);
        queue_op(OP_CONSTU, ALL_ONES, '0, 1'b0);
        queue_op(OP_LIT0 + 8'd7, '0, '0, 1'b0);
        queue_op(OP_CONST1U, 64'hff, '0, 1'b0);
        queue_op(OP_LIT0 + 8'd1, '0, '0, 1'b0);
        queue_op(OP_NOP, '0, '0, 1'b1);
        // arithmetic on the extremes
        queue_op(OP_CONSTS, ALL_ONES, '0, 1'b0);
        queue_op(OP_LIT31, '0, '0, 1'b0);
        queue_op(OP_SWAP, '0, '0, 1'b0);
        queue_op(OP_MINUS, '0, '0, 1'b0);
        queue_op(OP_DUP, '0, '0, 1'b0);
        queue_op(OP_MUL, '0, '0, 1'b0);
        queue_op(OP_NEG, '0, '0, 1'b0);
        queue_op(OP_PLUS_UCONST, ALL_ONES, '0, 1'b0);
        queue_op(OP_NOT, '0, '0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained(4);
            if (ph == PHASES - 1)
                quiet_tail = 1'b1;
            case ($urandom_range(0, 2))
                0:       src_odds = 0;
                1:       src_odds = 3;
                default: src_odds = 12;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_odds = 0;
                1:       sink_odds = 3;
                default: sink_odds = 12;
            endcase
            write_context(ph != 3 && ph != 6,
                          (ph == 2 || ph == 5) ? 64'd0 :
                              (ph == 1 ? ALL_ONES : {$urandom, $urandom}),
                          (ph % 3) != 2,
                          ph == 4 ? ALL_ONES : (ph == 0 ? 64'd0 : {$urandom, $urandom}));
            made = 0;
            while (made < ITEMS_TOTAL / PHASES)
            begin
                add_expression(n);
                made += n;
                // hold off the source until the block has answered everything
                if (ph == 3 && made >= ITEMS_TOTAL / PHASES / 2 &&
                    made - n < ITEMS_TOTAL / PHASES / 2)
                    wait_drained(0);
            end
        end

        wait_drained(8);
        if (bad == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
